>>> design/covalent_bond_inference_core_assert.svh
// Assertion macros for the checker file of the bond inference core.
`ifndef COVALENT_BOND_INFERENCE_CORE_ASSERT_SVH
`define COVALENT_BOND_INFERENCE_CORE_ASSERT_SVH

// Implication in the same cycle, disabled during reset.
`define CBI_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// Implication into the next cycle, disabled during reset.
`define CBI_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

// Implication into the next cycle that also holds across reset.
`define CBI_ASSERT_NEXT_ALWAYS(lbl, clk, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("assertion failed");

`endif

>>> design/cbi_pkg.sv
// Types, constants and the radius table of the bond inference core.
package cbi_pkg;

  localparam int COORD_W = 24;
  localparam int RADIUS_W = 8;
  localparam int SCALE_W = 12;
  localparam int OUT_IDX_W = 6;
  localparam int ZNUM_W = 7;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 12'd307;
  localparam logic [RADIUS_W-1:0] RADIUS_DEFAULT = 8'd99;

  typedef struct packed {
    logic                      first_of_molecule;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic signed [COORD_W-1:0] z_coord;
    logic [ZNUM_W-1:0]         element_number;
  } cbi_req_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] earlier_index;
    logic [OUT_IDX_W-1:0] new_index;
    logic                 last_bond;
  } cbi_res_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [RADIUS_W-1:0]       radius;
  } cbi_atom_t;

  typedef struct packed {
    logic in_flight;
  } cbi_cmp_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } cbi_state_t;

  // Covalent radius in units of 1/128 angstrom; potassium saturates.
  function automatic logic [RADIUS_W-1:0] radius_of(input logic [ZNUM_W-1:0] z);
    logic [RADIUS_W-1:0] r;
    unique case (z)
      7'd1:    r = 8'd40;
      7'd5:    r = 8'd108;
      7'd6:    r = 8'd97;
      7'd7:    r = 8'd91;
      7'd8:    r = 8'd84;
      7'd9:    r = 8'd73;
      7'd11:   r = 8'd212;
      7'd12:   r = 8'd180;
      7'd14:   r = 8'd142;
      7'd15:   r = 8'd137;
      7'd16:   r = 8'd134;
      7'd17:   r = 8'd131;
      7'd19:   r = 8'd255;
      7'd20:   r = 8'd225;
      7'd25:   r = 8'd178;
      7'd26:   r = 8'd169;
      7'd27:   r = 8'd161;
      7'd28:   r = 8'd159;
      7'd29:   r = 8'd169;
      7'd30:   r = 8'd156;
      7'd33:   r = 8'd152;
      7'd34:   r = 8'd154;
      7'd35:   r = 8'd154;
      7'd53:   r = 8'd178;
      default: r = RADIUS_DEFAULT;
    endcase
    return r;
  endfunction

endpackage

>>> design/cbi_cell.sv
// One storage cell of the atom ring: loads a new atom or takes its neighbor's.
module cbi_cell (
  input  logic              clk,
  input  logic              load,
  input  logic              shift,
  input  cbi_pkg::cbi_atom_t load_atom,
  input  cbi_pkg::cbi_atom_t shift_in,
  output cbi_pkg::cbi_atom_t atom
);
  import cbi_pkg::*;

  always_ff @(posedge clk) begin
    if (load) begin
      atom <= load_atom;
    end else if (shift) begin
      atom <= shift_in;
    end
  end

endmodule

>>> design/cbi_cmp.sv
// Four-stage distance test of the new atom against one stored atom.
module cbi_cmp #(
  parameter int IW = 6
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    issue,
  input  logic [IW-1:0]           tag,
  input  cbi_pkg::cbi_atom_t      new_atom,
  input  cbi_pkg::cbi_atom_t      old_atom,
  input  logic [cbi_pkg::SCALE_W-1:0] scale,
  output logic                    hit,
  output logic [IW-1:0]           hit_tag,
  output cbi_pkg::cbi_cmp_status_t status
);
  import cbi_pkg::*;

  logic                   v1, v2, v3;
  logic [IW-1:0]          t1, t2, t3;
  logic [COORD_W-1:0]     adx, ady, adz;
  logic [RADIUS_W:0]      rsum;
  logic [2*COORD_W-1:0]   sqx, sqy, sqz;
  logic [SCALE_W+RADIUS_W:0] lim;
  logic [2*COORD_W+1:0]   d2;
  logic [2*(SCALE_W+RADIUS_W+1)-1:0] lim2;
  logic signed [COORD_W:0] dx, dy, dz;
  logic [COORD_W:0]       mx, my, mz;

  always_comb begin
    dx = {new_atom.x[COORD_W-1], new_atom.x} - {old_atom.x[COORD_W-1], old_atom.x};
    dy = {new_atom.y[COORD_W-1], new_atom.y} - {old_atom.y[COORD_W-1], old_atom.y};
    dz = {new_atom.z[COORD_W-1], new_atom.z} - {old_atom.z[COORD_W-1], old_atom.z};
    mx = dx[COORD_W] ? -dx : dx;
    my = dy[COORD_W] ? -dy : dy;
    mz = dz[COORD_W] ? -dz : dz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      hit <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      hit <= v3 && ({d2, 6'b0} <= {{(2*COORD_W+8)-2*(SCALE_W+RADIUS_W+1){1'b0}}, lim2});
    end
  end

  always_ff @(posedge clk) begin
    t1 <= tag;
    adx <= mx[COORD_W-1:0];
    ady <= my[COORD_W-1:0];
    adz <= mz[COORD_W-1:0];
    rsum <= {1'b0, new_atom.radius} + {1'b0, old_atom.radius};
    t2 <= t1;
    sqx <= adx * adx;
    sqy <= ady * ady;
    sqz <= adz * adz;
    lim <= scale * rsum;
    t3 <= t2;
    d2 <= {2'b0, sqx} + {2'b0, sqy} + {2'b0, sqz};
    lim2 <= lim * lim;
    hit_tag <= t3;
  end

  assign status.in_flight = v1 || v2 || v3 || hit;

endmodule

>>> design/covalent_bond_inference_core.sv
// Top level of the bond inference core: atom ring, compare unit and control.
//
//  Channel   Signals                        Handshake
//  request   start, busy, request           taken when start && !busy
//  result    result_strobe, result          one cycle per bond, cannot stall
//  config    cfg_we, cfg_data               written when cfg_we
//
// A stored atom keeps busy high while the ring of cells rotates once past the
// compare unit, one stored atom a cycle, and then while the four-stage compare
// drains. The last bond shows in the first idle cycle, in which the next
// request can already be taken. An ignored atom (store full) leaves busy low.
// Reset is synchronous and clears control state only. Results are never held back.
module covalent_bond_inference_core #(
  parameter int MAX_ATOMS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  cbi_pkg::cbi_req_t           request,
  output logic                        result_strobe,
  output cbi_pkg::cbi_res_t           result,
  input  logic                        cfg_we,
  input  logic [cbi_pkg::SCALE_W-1:0] cfg_data
);
  import cbi_pkg::*;

  localparam int IW = $clog2(MAX_ATOMS);
  localparam int CW = $clog2(MAX_ATOMS + 1);

  cbi_state_t state, state_next;
  logic [SCALE_W-1:0] scale;
  logic [CW-1:0] atom_count;
  logic [CW-1:0] n;
  logic [IW-1:0] scan_cnt;
  cbi_atom_t new_atom;
  cbi_atom_t ring [MAX_ATOMS];
  cbi_atom_t load_atom;
  logic [CW-1:0] cnt_eff;
  logic accept, store;
  logic shift, issue, finish;
  logic hit;
  logic [IW-1:0] hit_tag;
  cbi_cmp_status_t cmp_status;
  logic pend_valid;
  logic [OUT_IDX_W-1:0] pend_idx;
  logic [IW+OUT_IDX_W-1:0] hit_wide, n_wide;

  assign accept = start && !busy;
  assign cnt_eff = request.first_of_molecule ? '0 : atom_count;
  assign store = accept && (cnt_eff < CW'(MAX_ATOMS));
  assign load_atom = '{x: request.x_coord, y: request.y_coord, z: request.z_coord,
                       radius: radius_of(request.element_number)};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (store) state_next = ST_SCAN;
      ST_SCAN:  if (scan_cnt == IW'(MAX_ATOMS - 1)) state_next = ST_DRAIN;
      ST_DRAIN: if (!cmp_status.in_flight) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != ST_IDLE);
    shift = (state == ST_SCAN);
    issue = (state == ST_SCAN) && (CW'(scan_cnt) < n);
    finish = (state == ST_DRAIN) && !cmp_status.in_flight;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      scale <= SCALE_RESET;
      atom_count <= '0;
      scan_cnt <= '0;
      pend_valid <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        scale <= cfg_data;
      end
      if (accept && request.first_of_molecule) begin
        atom_count <= '0;
      end
      if (store) begin
        atom_count <= cnt_eff + CW'(1);
      end
      scan_cnt <= shift ? scan_cnt + IW'(1) : '0;
      result_strobe <= 1'b0;
      if (hit) begin
        pend_valid <= 1'b1;
        result_strobe <= pend_valid;
      end else if (finish) begin
        pend_valid <= 1'b0;
        result_strobe <= pend_valid;
      end
    end
  end

  assign hit_wide = {{OUT_IDX_W{1'b0}}, hit_tag};
  assign n_wide = {{(IW+OUT_IDX_W-CW){1'b0}}, n};

  always_ff @(posedge clk) begin
    if (store) begin
      n <= cnt_eff;
      new_atom <= load_atom;
    end
    if (hit) begin
      pend_idx <= hit_wide[OUT_IDX_W-1:0];
      result.earlier_index <= pend_idx;
      result.last_bond <= 1'b0;
    end else if (finish) begin
      result.earlier_index <= pend_idx;
      result.last_bond <= 1'b1;
    end
    result.new_index <= n_wide[OUT_IDX_W-1:0];
  end

  for (genvar k = 0; k < MAX_ATOMS; k++) begin : g_ring
    cbi_cell u_cell (
      .clk       (clk),
      .load      (store && (cnt_eff[IW-1:0] == IW'(k))),
      .shift     (shift),
      .load_atom (load_atom),
      .shift_in  (ring[(k + 1) % MAX_ATOMS]),
      .atom      (ring[k])
    );
  end

  cbi_cmp #(
    .IW(IW)
  ) u_cmp (
    .clk      (clk),
    .rst      (rst),
    .issue    (issue),
    .tag      (scan_cnt),
    .new_atom (new_atom),
    .old_atom (ring[0]),
    .scale    (scale),
    .hit      (hit),
    .hit_tag  (hit_tag),
    .status   (cmp_status)
  );

endmodule

>>> design/cbi_checker.sv
// Port checker of the bond inference core and its bind statement.
`include "covalent_bond_inference_core_assert.svh"

module cbi_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              result_strobe,
  input cbi_pkg::cbi_res_t result
);
  import cbi_pkg::*;

  `CBI_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, rst, !busy && !result_strobe)
  `CBI_ASSERT_NEXT(a_strobe_in_run, clk, rst, !busy && !result_strobe, !result_strobe)
  `CBI_ASSERT_IMP(a_more_follow, clk, rst, result_strobe && !result.last_bond, busy)
  `CBI_ASSERT_IMP(a_last_ends_run, clk, rst, result_strobe && result.last_bond, !busy)
  `CBI_ASSERT_IMP(a_new_index_steady, clk, rst, result_strobe && $past(result_strobe),
                  result.new_index == $past(result.new_index))

endmodule

bind covalent_bond_inference_core cbi_checker u_cbi_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .result_strobe (result_strobe),
  .result        (result)
);

>>> sim/testbench.sv
// Self-checking testbench for the covalent bond inference core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cbi_pkg::*;

  localparam int MAX_ATOMS = 64;
  localparam int DRAIN_CYCLES = MAX_ATOMS + 16;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = -24'sh800000;
  localparam int ANGSTROM = 4096;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  cbi_req_t request = '0;
  logic result_strobe;
  cbi_res_t result;
  logic cfg_we = 1'b0;
  logic [SCALE_W-1:0] cfg_data = '0;

  covalent_bond_inference_core #(.MAX_ATOMS(MAX_ATOMS)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .result_strobe(result_strobe), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  logic signed [COORD_W-1:0] x_mem [MAX_ATOMS];
  logic signed [COORD_W-1:0] y_mem [MAX_ATOMS];
  logic signed [COORD_W-1:0] z_mem [MAX_ATOMS];
  logic [RADIUS_W-1:0] r_mem [MAX_ATOMS];
  int stored_atoms = 0;
  logic [SCALE_W-1:0] scale_now = SCALE_RESET;
  cbi_res_t pending_bonds[$];
  int err_count = 0;
  bit gaps_on = 1'b1;

  function automatic logic [RADIUS_W-1:0] element_radius(logic [ZNUM_W-1:0] zn);
    case (zn)
      7'd1: return 8'd40;    7'd5: return 8'd108;   7'd6: return 8'd97;
      7'd7: return 8'd91;    7'd8: return 8'd84;    7'd9: return 8'd73;
      7'd11: return 8'd212;  7'd12: return 8'd180;  7'd14: return 8'd142;
      7'd15: return 8'd137;  7'd16: return 8'd134;  7'd17: return 8'd131;
      7'd19: return 8'd255;  7'd20: return 8'd225;  7'd25: return 8'd178;
      7'd26: return 8'd169;  7'd27: return 8'd161;  7'd28: return 8'd159;
      7'd29: return 8'd169;  7'd30: return 8'd156;  7'd33: return 8'd152;
      7'd34: return 8'd154;  7'd35: return 8'd154;  7'd53: return 8'd178;
      default: return 8'd99;
    endcase
  endfunction

  function automatic longint unsigned sq_delta(logic signed [COORD_W-1:0] a,
                                               logic signed [COORD_W-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    return longint'(d * d);
  endfunction

  function automatic void predict_bonds(cbi_req_t a);
    longint unsigned d2, lim;
    logic [RADIUS_W-1:0] r;
    cbi_res_t b;
    int n, found;
    found = 0;
    if (a.first_of_molecule) stored_atoms = 0;
    if (stored_atoms >= MAX_ATOMS) return;
    n = stored_atoms;
    r = element_radius(a.element_number);
    x_mem[n] = a.x_coord;
    y_mem[n] = a.y_coord;
    z_mem[n] = a.z_coord;
    r_mem[n] = r;
    stored_atoms = n + 1;
    for (int i = 0; i < n; i++) begin
      d2 = sq_delta(a.x_coord, x_mem[i]) + sq_delta(a.y_coord, y_mem[i]) +
           sq_delta(a.z_coord, z_mem[i]);
      lim = longint'(scale_now) * (longint'(r) + longint'(r_mem[i]));
      if ((d2 << 6) <= lim * lim) begin
        b.earlier_index = i[OUT_IDX_W-1:0];
        b.new_index = n[OUT_IDX_W-1:0];
        b.last_bond = 1'b0;
        pending_bonds.insert(pending_bonds.size(), b);
        found++;
      end
    end
    if (found > 0) pending_bonds[pending_bonds.size()-1].last_bond = 1'b1;
  endfunction

  always @(posedge clk) begin
    cbi_res_t exp_bond;
    if (!rst && result_strobe) begin
      if (pending_bonds.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected bond %0d-%0d last=%0b",
          result.earlier_index, result.new_index, result.last_bond);
      end else begin
        exp_bond = pending_bonds.pop_front();
        if (result.earlier_index !== exp_bond.earlier_index ||
            result.new_index !== exp_bond.new_index ||
            result.last_bond !== exp_bond.last_bond) begin
          err_count++;
          if (err_count <= 10)
            $display("bond mismatch: expected %0d-%0d last=%0b, got %0d-%0d last=%0b",
              exp_bond.earlier_index, exp_bond.new_index, exp_bond.last_bond,
              result.earlier_index, result.new_index, result.last_bond);
        end
      end
    end
  end

  task automatic send_atom(cbi_req_t a);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    start <= 1'b1;
    request <= a;
    do @(posedge clk); while (busy);
    predict_bonds(a);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_bonds.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_scale(logic [SCALE_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    scale_now = v;
  endtask

  function automatic cbi_req_t make_atom(bit first, int xa, int ya, int za, int zn);
    cbi_req_t a;
    a.first_of_molecule = first;
    a.x_coord = xa[COORD_W-1:0];
    a.y_coord = ya[COORD_W-1:0];
    a.z_coord = za[COORD_W-1:0];
    a.element_number = zn[ZNUM_W-1:0];
    return a;
  endfunction

  function automatic cbi_req_t random_atom(bit first, int spread);
    int zn;
    int pick[8] = '{1, 6, 7, 8, 16, 19, 35, 53};
    zn = ($urandom_range(0, 1) == 0) ? pick[$urandom_range(0, 7)] : $urandom_range(0, 127);
    if (spread == 0)
      return make_atom(first, $urandom(), $urandom(), $urandom(), zn);
    return make_atom(first, int'($urandom_range(0, 2 * spread)) - spread,
      int'($urandom_range(0, 2 * spread)) - spread,
      int'($urandom_range(0, 2 * spread)) - spread, zn);
  endfunction

  task automatic test_directed_cases();
    send_atom(make_atom(1, 0, 0, 0, 1));
    send_atom(make_atom(0, 3000, 0, 0, 1));
    send_atom(make_atom(0, 0, 5000, 0, 6));
    send_atom(make_atom(0, 0, 0, 6000, 19));
    send_atom(make_atom(0, 0, 0, 0, 0));
    send_atom(make_atom(0, 0, 0, 0, 127));
    send_atom(make_atom(0, 200000, 200000, 200000, 8));
    send_atom(make_atom(1, COORD_MAX, COORD_MAX, COORD_MAX, 19));
    send_atom(make_atom(0, COORD_MIN, COORD_MIN, COORD_MIN, 19));
    send_atom(make_atom(0, COORD_MAX, COORD_MAX, COORD_MAX, 53));
    send_atom(make_atom(0, COORD_MIN, COORD_MAX, COORD_MIN, 7));
    send_atom(make_atom(0, COORD_MIN + 100, COORD_MAX, COORD_MIN, 9));
    send_atom(make_atom(1, 0, 0, 0, 11));
    send_atom(make_atom(0, 0, 0, 0, 20));
    send_atom(make_atom(0, 2 * ANGSTROM, 0, 0, 35));
    send_atom(make_atom(0, -3 * ANGSTROM, 0, 0, 14));
  endtask

  task automatic test_store_full();
    wait_idle();
    write_scale(12'd307);
    for (int k = 0; k < MAX_ATOMS + 4; k++)
      send_atom(random_atom(k == 0, 3 * ANGSTROM));
    send_atom(make_atom(1, 0, 0, 0, 6));
    send_atom(make_atom(0, ANGSTROM, 0, 0, 6));
  endtask

  task automatic test_scale_extremes();
    logic [SCALE_W-1:0] settings[3] = '{12'd0, 12'd4095, 12'd128};
    foreach (settings[s]) begin
      wait_idle();
      write_scale(settings[s]);
      send_atom(make_atom(1, 0, 0, 0, 6));
      send_atom(make_atom(0, 0, 0, 0, 8));
      for (int k = 0; k < 6; k++) send_atom(random_atom(0, 20 * ANGSTROM));
    end
  endtask

  task automatic test_random_molecules();
    int sent, sz;
    bit rescaled;
    sent = 0;
    rescaled = 1'b0;
    wait_idle();
    write_scale(SCALE_RESET);
    while (sent < 50) begin
      if (sent > 30) gaps_on = 1'b0;
      if (sent >= 20 && !rescaled) begin
        rescaled = 1'b1;
        wait_idle();
        write_scale(12'($urandom_range(200, 500)));
      end
      sz = $urandom_range(1, 12);
      for (int k = 0; k < sz; k++) begin
        if ($urandom_range(0, 9) == 0)
          send_atom(random_atom($urandom_range(0, 1) == 1, 0));
        else send_atom(random_atom(k == 0, 2 * ANGSTROM));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_store_full();
    test_scale_extremes();
    test_random_molecules();
    wait_idle();
    if (err_count == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench: done, errors");
    $finish;
  end
endmodule
